// ----- hdl/bfda_pkg.sv -----
package bfda_pkg;

  // Fixed field widths of the input and result words.
  localparam int DLY_W       = 10;
  localparam int FRAC_W      = 5;
  localparam int IPART_W     = DLY_W - FRAC_W;
  localparam int PTR_W       = 10;
  localparam int GROUP       = 4;
  localparam int PACKED_W    = GROUP * DLY_W;
  localparam int SENSORS     = 16;
  localparam int SENS_W      = $clog2(SENSORS);
  localparam int WNEW_W      = FRAC_W + 1;
  localparam int ADDR_WIDTH_DEF = 10;

  localparam logic [WNEW_W-1:0]  ONE_SAMPLE  = WNEW_W'(32);
  localparam logic [SENS_W-1:0]  LAST_SENSOR = SENS_W'(SENSORS - 1);

  typedef logic signed [DLY_W-1:0] dly_t;

  typedef struct packed {
    logic [PACKED_W-1:0] packed_delays;
    logic [PTR_W-1:0]    write_pointer;
  } in_word_t;

  typedef struct packed {
    logic [SENS_W-1:0] sensor;
    logic [PTR_W-1:0]  read_addr_older;
    logic [PTR_W-1:0]  read_addr_newer;
    logic [FRAC_W-1:0] weight_older;
    logic [WNEW_W-1:0] weight_newer;
    logic              last;
  } out_word_t;

  // Per-sensor result held in the output buffer.
  typedef struct packed {
    logic [PTR_W-1:0]  read_addr_older;
    logic [PTR_W-1:0]  read_addr_newer;
    logic [FRAC_W-1:0] weight_older;
    logic [WNEW_W-1:0] weight_newer;
  } res_t;

  // Stage enables for the minimum tree.
  typedef struct packed {
    logic en_a;
    logic en_b;
  } tree_ctl_t;

endpackage

// ----- hdl/bfda_stream_if.sv -----
interface bfda_stream_if import bfda_pkg::*; #(
  parameter type payload_t = in_word_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/bfda_lane.sv -----
module bfda_lane import bfda_pkg::*; #(
  parameter int IDX        = 0,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic [PACKED_W-1:0] packed_delays,
  output dly_t                dly_o,
  input  dly_t                dly_i,
  input  dly_t                mn_i,
  input  logic [PTR_W-1:0]    wp_i,
  output res_t                res_o
);

  localparam int BASE_LSB = (GROUP - 1 - (IDX % GROUP)) * DLY_W;
  localparam bit NEG      = ((IDX / GROUP) % 2) == 1;
  localparam bit SHIFT    = (IDX / (2 * GROUP)) == 1;
  localparam int EAW      = (ADDR_WIDTH < PTR_W) ? ADDR_WIDTH : PTR_W;

  dly_t                base;
  dly_t                sel;
  logic signed [DLY_W:0] diff;
  logic [DLY_W-1:0]    adj;
  logic [EAW-1:0]      newer;
  logic [EAW-1:0]      older;

  // Sensor delay derivation: one of the four steering delays, optionally
  // negated with wrap, optionally halved toward minus infinity.
  always_comb begin
    base = packed_delays[BASE_LSB +: DLY_W];
    sel  = NEG ? dly_t'(~base + 1'b1) : base;
    dly_o = SHIFT ? (sel >>> 1) : sel;
  end

  // Adjusted delay is never negative and fits in ten bits.
  always_comb begin
    diff  = {dly_i[DLY_W-1], dly_i} - {mn_i[DLY_W-1], mn_i};
    adj   = diff[DLY_W-1:0];
    newer = wp_i[EAW-1:0] - EAW'(adj[DLY_W-1:FRAC_W]);
    older = newer - EAW'(1);
    res_o.read_addr_newer = PTR_W'(newer);
    res_o.read_addr_older = PTR_W'(older);
    res_o.weight_older    = adj[FRAC_W-1:0];
    res_o.weight_newer    = ONE_SAMPLE - {1'b0, adj[FRAC_W-1:0]};
  end

endmodule

// ----- hdl/bfda_min_tree.sv -----
module bfda_min_tree import bfda_pkg::*; (
  input  logic      clk,
  input  tree_ctl_t ctl,
  input  dly_t      dly_i [SENSORS],
  output dly_t      mn_o
);

  localparam int QUADS = SENSORS / 4;

  dly_t quad_nxt [QUADS];
  dly_t quad_r   [QUADS];
  dly_t mn_nxt;
  dly_t mn_r;

  function automatic dly_t min2(input dly_t a, input dly_t b);
    return (b < a) ? b : a;
  endfunction

  // First stage reduces groups of four, second stage the four partials.
  always_comb begin
    for (int q = 0; q < QUADS; q++) begin
      quad_nxt[q] = min2(min2(dly_i[4*q], dly_i[4*q+1]),
                         min2(dly_i[4*q+2], dly_i[4*q+3]));
    end
    mn_nxt = min2(min2(quad_r[0], quad_r[1]), min2(quad_r[2], quad_r[3]));
  end

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      quad_r <= quad_nxt;
    end
    if (ctl.en_b) begin
      mn_r <= mn_nxt;
    end
  end

  assign mn_o = mn_r;

endmodule

// ----- hdl/bfda_serializer.sv -----
module bfda_serializer import bfda_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_i [SENSORS],
  output logic buf_free,
  bfda_stream_if.source out_s
);

  res_t              buf_r [SENSORS];
  logic [SENS_W-1:0] cnt_r;
  logic [SENS_W-1:0] cnt_nxt;
  logic              bv_r;
  logic              bv_nxt;
  logic              fire;
  logic              last_fire;

  assign fire      = bv_r && out_s.ready;
  assign last_fire = fire && (cnt_r == LAST_SENSOR);
  assign buf_free  = !bv_r || last_fire;

  always_comb begin
    cnt_nxt = cnt_r;
    bv_nxt  = bv_r;
    if (load) begin
      cnt_nxt = '0;
      bv_nxt  = 1'b1;
    end else if (last_fire) begin
      bv_nxt  = 1'b0;
    end else if (fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      bv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      bv_r  <= bv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= res_i;
    end
  end

  always_comb begin
    out_s.valid                = bv_r;
    out_s.data.sensor          = cnt_r;
    out_s.data.read_addr_older = buf_r[cnt_r].read_addr_older;
    out_s.data.read_addr_newer = buf_r[cnt_r].read_addr_newer;
    out_s.data.weight_older    = buf_r[cnt_r].weight_older;
    out_s.data.weight_newer    = buf_r[cnt_r].weight_newer;
    out_s.data.last            = (cnt_r == LAST_SENSOR);
  end

endmodule

// ----- hdl/beamform_fractional_delay_addresses.sv -----
// Fractional-delay read address generator for a sixteen-sensor delay-and-sum
// beamformer. Each input word carries four signed steering delays (ten bits,
// five of them fraction, in 1/32 sample) and the delay buffer write pointer.
// The block derives sixteen sensor delays (the four, their negations and all
// eight halved), removes their common minimum, and emits sixteen result words,
// sensor 0 first, each with the newer and older buffer read addresses and the
// two linear interpolation weights; last marks sensor 15. Only the low
// ADDR_WIDTH bits of the write pointer take part in the address arithmetic.
// Pipeline: a word runs through three register stages (lane capture, then a
// two-stage registered minimum tree) before its results are loaded into the
// output buffer. The output port delivers one result per cycle while
// out_s.ready is held high; that single result port sets the throughput. Up
// to three further words are accepted into the pipeline while a buffered
// word is still draining, and the buffer reloads in the cycle its last
// result is taken, so words follow each other with no gap on the output.

module beamform_fractional_delay_addresses import bfda_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bfda_stream_if.sink   in_s,
  bfda_stream_if.source out_s
);

  dly_t             lane_dly [SENSORS];
  res_t             lane_res [SENSORS];
  dly_t             mn;
  tree_ctl_t        tree_ctl;

  logic             v1_r, v2_r, v3_r;
  logic             v1_nxt, v2_nxt, v3_nxt;
  dly_t             dly1_r [SENSORS];
  dly_t             dly2_r [SENSORS];
  dly_t             dly3_r [SENSORS];
  logic [PTR_W-1:0] wp1_r, wp2_r, wp3_r;

  logic             acc, adv1, adv2, load;
  logic             rdy1, rdy2, rdy3;
  logic             buf_free;

  // One lane per sensor: derivation at the front, address and weight
  // generation at the back once the minimum is known.
  for (genvar i = 0; i < SENSORS; i++) begin : g_lane
    bfda_lane #(
      .IDX        (i),
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_lane (
      .packed_delays (in_s.data.packed_delays),
      .dly_o         (lane_dly[i]),
      .dly_i         (dly3_r[i]),
      .mn_i          (mn),
      .wp_i          (wp3_r),
      .res_o         (lane_res[i])
    );
  end

  // Each stage moves on when the stage after it is empty or moving.
  always_comb begin
    load = v3_r && buf_free;
    rdy3 = !v3_r || load;
    adv2 = v2_r && rdy3;
    rdy2 = !v2_r || rdy3;
    adv1 = v1_r && rdy2;
    rdy1 = !v1_r || rdy2;
    acc  = in_s.valid && rdy1;
    v1_nxt = acc || (v1_r && !adv1);
    v2_nxt = adv1 || (v2_r && !adv2);
    v3_nxt = adv2 || (v3_r && !load);
    tree_ctl.en_a = adv1;
    tree_ctl.en_b = adv2;
  end

  assign in_s.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // The delay copies travel alongside the minimum tree stages.
  always_ff @(posedge clk) begin
    if (acc) begin
      dly1_r <= lane_dly;
      wp1_r  <= in_s.data.write_pointer;
    end
    if (adv1) begin
      dly2_r <= dly1_r;
      wp2_r  <= wp1_r;
    end
    if (adv2) begin
      dly3_r <= dly2_r;
      wp3_r  <= wp2_r;
    end
  end

  bfda_min_tree u_min_tree (
    .clk   (clk),
    .ctl   (tree_ctl),
    .dly_i (dly1_r),
    .mn_o  (mn)
  );

  bfda_serializer u_serializer (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .res_i    (lane_res),
    .buf_free (buf_free),
    .out_s    (out_s)
  );

endmodule

// ----- hdl/bfda_checker.sv -----
module bfda_checker import bfda_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // The last flag marks exactly the final sensor of a word.
  a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.sensor == LAST_SENSOR)))
    else $error("last flag does not match sensor index");

  // The two interpolation weights always add up to one sample.
  a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.weight_newer + WNEW_W'(out_data.weight_older))
                   == ONE_SAMPLE))
    else $error("interpolation weights do not sum to one sample");

  // Within a word the sensors follow each other without a gap.
  a_sensor_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=>
      (out_valid && (out_data.sensor == $past(out_data.sensor) + 1'b1)))
    else $error("sensor sequence broken within a word");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word changed while stalled");

endmodule

bind beamform_fractional_delay_addresses bfda_checker u_bfda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  (out_s.data)
);
